// ===== design/dlf_pkg.sv =====
package dlf_pkg;

    // Fixed field widths
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int DIAM_BITS  = 18;
    localparam int RAD_BITS   = DIAM_BITS - 1;
    localparam int ABS_BITS   = COORD_BITS;
    localparam int SQ_BITS    = 2 * ABS_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    localparam int DIST_BITS  = 25;
    localparam int WGT_BITS   = 16;
    localparam int SPAN_BITS  = RAD_BITS + FRAC_BITS;
    localparam int IDX_BITS   = 2;

    localparam logic [WGT_BITS-1:0] ONE_Q15 = 16'd32768;

    // Register indexes
    localparam logic [IDX_BITS-1:0] REG_INNER = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_OUTER = 2'd1;

    // Weight class decided in the front part
    typedef enum logic [1:0] {
        CLS_ONE,
        CLS_ZERO,
        CLS_RAMP
    } cls_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] az;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] bz;
    } in_word_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance_q8;
        logic [WGT_BITS-1:0]  influence_q15;
    } out_word_t;

    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        cls_t                cls;
    } mid_word_t;

    // Values derived from the radii
    typedef struct packed {
        logic [SUM_BITS-1:0]  rin_sq;
        logic [SUM_BITS-1:0]  rout_sq;
        logic                 radii_equal;
        logic [RAD_BITS-1:0]  rout;
        logic [SPAN_BITS-1:0] span;
    } radii_t;

endpackage

// ===== design/dlf_fifo.sv =====
module dlf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/dlf_front.sv =====
module dlf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               take,
    input  dlf_pkg::in_word_t  item,
    input  dlf_pkg::radii_t    radii,
    output logic               mid_wr,
    output dlf_pkg::mid_word_t mid_word
);

    logic                          s0_valid_reg, s1_valid_reg, s2_valid_reg;
    logic [dlf_pkg::ABS_BITS-1:0]  ux_reg, uy_reg, uz_reg;
    logic [dlf_pkg::SQ_BITS-1:0]   qx_reg, qy_reg, qz_reg;
    logic [dlf_pkg::SUM_BITS-1:0]  sum_reg;
    logic signed [dlf_pkg::COORD_BITS:0] dx, dy, dz;

    // coordinate differences, sign-extended by one bit
    assign dx = {item.bx[dlf_pkg::COORD_BITS-1], item.bx}
              - {item.ax[dlf_pkg::COORD_BITS-1], item.ax};
    assign dy = {item.by[dlf_pkg::COORD_BITS-1], item.by}
              - {item.ay[dlf_pkg::COORD_BITS-1], item.ay};
    assign dz = {item.bz[dlf_pkg::COORD_BITS-1], item.bz}
              - {item.az[dlf_pkg::COORD_BITS-1], item.az};

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= take;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // abs diff, square, sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg  <= dlf_pkg::ABS_BITS'(dx[dlf_pkg::COORD_BITS] ? -dx : dx);
            uy_reg  <= dlf_pkg::ABS_BITS'(dy[dlf_pkg::COORD_BITS] ? -dy : dy);
            uz_reg  <= dlf_pkg::ABS_BITS'(dz[dlf_pkg::COORD_BITS] ? -dz : dz);
            qx_reg  <= ux_reg * ux_reg;
            qy_reg  <= uy_reg * uy_reg;
            qz_reg  <= uz_reg * uz_reg;
            sum_reg <= dlf_pkg::SUM_BITS'(qx_reg) + dlf_pkg::SUM_BITS'(qy_reg)
                     + dlf_pkg::SUM_BITS'(qz_reg);
        end
    end

    // classify against the squared radii
    always_comb
    begin
        mid_word.sum = sum_reg;
        if (sum_reg < radii.rin_sq)
        begin
            mid_word.cls = dlf_pkg::CLS_ONE;
        end
        else if (sum_reg > radii.rout_sq)
        begin
            mid_word.cls = dlf_pkg::CLS_ZERO;
        end
        else if (radii.radii_equal)
        begin
            mid_word.cls = dlf_pkg::CLS_ONE;
        end
        else
        begin
            mid_word.cls = dlf_pkg::CLS_RAMP;
        end
    end

    assign mid_wr = en && s2_valid_reg;

endmodule

// ===== design/dlf_back.sv =====
module dlf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               mid_empty,
    input  dlf_pkg::mid_word_t mid_word,
    input  dlf_pkg::radii_t    radii,
    output logic               mid_rd,
    output logic               out_wr,
    output dlf_pkg::out_word_t out_word
);

    localparam int RAD_W    = 2 * dlf_pkg::DIST_BITS;
    localparam int ROOT_W   = dlf_pkg::DIST_BITS;
    localparam int REM_W    = ROOT_W + 3;
    localparam int SQ_STEPS = ROOT_W;
    localparam int DV_STEPS = dlf_pkg::WGT_BITS;
    localparam int DREM_W   = dlf_pkg::SPAN_BITS + 1;

    // square root pipeline, one result bit per stage
    logic                sq_valid_reg [SQ_STEPS+1];
    logic [RAD_W-1:0]    sq_rad_reg   [SQ_STEPS+1];
    logic [REM_W-1:0]    sq_rem_reg   [SQ_STEPS+1];
    logic [ROOT_W-1:0]   sq_root_reg  [SQ_STEPS+1];
    dlf_pkg::cls_t       sq_cls_reg   [SQ_STEPS+1];

    // divider pipeline, one quotient bit per stage
    logic                dv_valid_reg [DV_STEPS+1];
    logic [DREM_W-1:0]   dv_rem_reg   [DV_STEPS+1];
    logic [DV_STEPS-1:0] dv_q_reg     [DV_STEPS+1];
    logic [ROOT_W-1:0]   dv_root_reg  [DV_STEPS+1];
    dlf_pkg::cls_t       dv_cls_reg   [DV_STEPS+1];

    assign mid_rd = en && !mid_empty;

    // sqrt entry: radicand is the sum scaled by 2^(2*FRAC_BITS)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_rad_reg[0]  <= RAD_W'({mid_word.sum, {(2 * dlf_pkg::FRAC_BITS){1'b0}}});
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_cls_reg[0]  <= mid_word.cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg[0] <= mid_rd;
        end
    end

    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_sq
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;

        assign rem_sh = {sq_rem_reg[i][REM_W-3:0], sq_rad_reg[i][RAD_W-1 -: 2]};
        assign trial  = REM_W'({sq_root_reg[i], 2'b01});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_valid_reg[i+1] <= sq_valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rad_reg[i+1] <= sq_rad_reg[i] << 2;
                sq_cls_reg[i+1] <= sq_cls_reg[i];
                if (rem_sh >= trial)
                begin
                    sq_rem_reg[i+1]  <= rem_sh - trial;
                    sq_root_reg[i+1] <= {sq_root_reg[i][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[i+1]  <= rem_sh;
                    sq_root_reg[i+1] <= {sq_root_reg[i][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // divider entry: numerator is outer radius minus distance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_rem_reg[0]  <= DREM_W'({radii.rout, {dlf_pkg::FRAC_BITS{1'b0}}})
                            - DREM_W'(sq_root_reg[SQ_STEPS]);
            dv_q_reg[0]    <= '0;
            dv_root_reg[0] <= sq_root_reg[SQ_STEPS];
            dv_cls_reg[0]  <= sq_cls_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= sq_valid_reg[SQ_STEPS];
        end
    end

    for (genvar j = 0; j < DV_STEPS; j++)
    begin : g_dv
        logic [DREM_W-1:0] r;
        logic [DREM_W-1:0] span;
        logic              ge;

        // first step tests the unit bit, later steps shift in a zero
        if (j == 0)
        begin : g_first
            assign r = dv_rem_reg[j];
        end
        else
        begin : g_rest
            assign r = {dv_rem_reg[j][DREM_W-2:0], 1'b0};
        end

        assign span = DREM_W'(radii.span);
        assign ge   = (r >= span);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[j+1]  <= ge ? r - span : r;
                dv_q_reg[j+1]    <= {dv_q_reg[j][DV_STEPS-2:0], ge};
                dv_root_reg[j+1] <= dv_root_reg[j];
                dv_cls_reg[j+1]  <= dv_cls_reg[j];
            end
        end
    end

    // final weight selection
    always_comb
    begin
        out_word.distance_q8 = dv_root_reg[DV_STEPS];
        case (dv_cls_reg[DV_STEPS])
            dlf_pkg::CLS_ONE:  out_word.influence_q15 = dlf_pkg::ONE_Q15;
            dlf_pkg::CLS_ZERO: out_word.influence_q15 = '0;
            dlf_pkg::CLS_RAMP: out_word.influence_q15 = dv_q_reg[DV_STEPS];
            default:           out_word.influence_q15 = '0;
        endcase
    end

    assign out_wr = en && dv_valid_reg[DV_STEPS];

endmodule

// ===== design/distance_linear_falloff.sv =====
// Throughput: one word per cycle while no queue is full; square root (25 stages) and divider
// (16 stages) are fully pipelined, and the whole back part stalls only on a full result queue.
// Reset: asynchronous, active low; clears all queues and valid bits and sets
// inner_diameter to 2 and outer_diameter to 6.
module distance_linear_falloff (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  dlf_pkg::in_word_t                 item,
    output logic                              empty,
    input  logic                              pop,
    output dlf_pkg::out_word_t                result,
    input  logic                              cfg_we,
    input  logic [dlf_pkg::IDX_BITS-1:0]      cfg_index,
    input  logic [dlf_pkg::DIAM_BITS-1:0]     cfg_data
);

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    logic [dlf_pkg::DIAM_BITS-1:0] inner_reg, outer_reg;
    dlf_pkg::radii_t               radii_reg, radii_next;
    logic [dlf_pkg::RAD_BITS-1:0]  rin, rout;

    logic               mid_full, mid_empty, mid_wr, mid_rd;
    dlf_pkg::mid_word_t mid_in, mid_out;
    logic               out_full, out_wr;
    dlf_pkg::out_word_t out_in;
    logic               front_en, back_en, take;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_reg <= 18'd2;
            outer_reg <= 18'd6;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dlf_pkg::REG_INNER: inner_reg <= cfg_data;
                dlf_pkg::REG_OUTER: outer_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // radii and derived constants
    assign rin  = inner_reg[dlf_pkg::DIAM_BITS-1:1];
    assign rout = outer_reg[dlf_pkg::DIAM_BITS-1:1];

    always_comb
    begin
        radii_next.rin_sq      = dlf_pkg::SUM_BITS'(rin) * dlf_pkg::SUM_BITS'(rin);
        radii_next.rout_sq     = dlf_pkg::SUM_BITS'(rout) * dlf_pkg::SUM_BITS'(rout);
        radii_next.radii_equal = (rin == rout);
        radii_next.rout        = rout;
        radii_next.span        = {rout - rin, {dlf_pkg::FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radii_reg.rin_sq      <= 34'd1;
            radii_reg.rout_sq     <= 34'd9;
            radii_reg.radii_equal <= 1'b0;
            radii_reg.rout        <= 17'd3;
            radii_reg.span        <= 25'd512;
        end
        else
        begin
            radii_reg <= radii_next;
        end
    end

    // handshake
    assign front_en = !mid_full;
    assign back_en  = !out_full;
    assign full     = mid_full;
    assign take     = push && !mid_full;

    dlf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (front_en),
        .take     (take),
        .item     (item),
        .radii    (radii_reg),
        .mid_wr   (mid_wr),
        .mid_word (mid_in)
    );

    dlf_fifo #(
        .WIDTH ($bits(dlf_pkg::mid_word_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (mid_wr),
        .wr_data (mid_in),
        .rd      (mid_rd),
        .rd_data (mid_out),
        .full    (mid_full),
        .empty   (mid_empty)
    );

    dlf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .mid_empty (mid_empty),
        .mid_word  (mid_out),
        .radii     (radii_reg),
        .mid_rd    (mid_rd),
        .out_wr    (out_wr),
        .out_word  (out_in)
    );

    dlf_fifo #(
        .WIDTH ($bits(dlf_pkg::out_word_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (out_wr),
        .wr_data (out_in),
        .rd      (pop && !empty),
        .rd_data (result),
        .full    (out_full),
        .empty   (empty)
    );

endmodule
